// File: rtl/core/ntm_pkg.sv
// ----------------------------------------------------------------------------
// ntm_pkg
// Types, constants and tables shared by the measurement generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ntm_pkg;

    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_INC      = 32'd1013904223;
    localparam logic [30:0] TWO_LN2_Q30  = 31'd1488522236;
    localparam logic [29:0] CLAMP_L_Q24  = 30'd927143219;
    localparam logic [33:0] CORDIC_K0    = 34'd652032874;

    localparam logic [1:0] CFG_RNG_SEED   = 2'd0;
    localparam logic [1:0] CFG_DROP_THR   = 2'd1;
    localparam logic [1:0] CFG_NOISE_SIG  = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic               mode;
        logic        [2:0]  slot;
        logic        [15:0] contact_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [19:0] dt;
    } t_cmd;

    typedef struct packed {
        logic        [15:0] meas_id;
        logic        [47:0] time_stamp;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [31:0] meas_z;
        logic               last;
    } t_meas;

    // One table entry; axis 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        logic [15:0]      ident;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_contact;

    typedef struct packed {
        logic        start;
        logic [23:0] u1;
        logic [23:0] u2;
    } t_gauss_req;

    typedef struct packed {
        logic               done;
        logic signed [29:0] n;
    } t_gauss_rsp;

    // Arctangent of 2^-i as a fraction of a full turn, 32-bit scale.
    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            4'd15:   v = 32'h0000517D;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ntm_gauss.sv
// ----------------------------------------------------------------------------
// ntm_gauss
// Box-Muller sample from two 24-bit uniforms: iterative log2, bit-serial
// square root and a CORDIC cosine that runs alongside the logarithm.
// ----------------------------------------------------------------------------
`default_nettype none

module ntm_gauss
    import ntm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_gauss_req i_req,
    output t_gauss_rsp      o_rsp
);

    typedef enum logic [2:0] {
        G_IDLE,
        G_LOG,
        G_LN,
        G_SQRT,
        G_MUL
    } t_gstate;

    t_gstate            r_state;
    logic        [4:0]  r_cnt;
    logic        [4:0]  r_exp;
    logic               r_zero;
    logic        [31:0] r_m;
    logic        [23:0] r_f;
    logic        [63:0] r_v;
    logic        [63:0] r_res;
    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic signed [33:0] r_cz;
    logic               r_neg;

    logic        [4:0]  n_exp;
    logic        [23:0] n_p;
    logic               n_neg;
    logic        [63:0] n_sq;
    logic        [28:0] n_d;
    logic        [59:0] n_lprod;
    logic        [63:0] n_bit;
    logic        [63:0] n_trial;
    logic signed [33:0] n_dx;
    logic signed [33:0] n_dy;
    logic signed [33:0] n_atan;
    logic signed [33:0] n_cos;
    logic signed [62:0] n_rprod;

    always_comb begin
        n_exp = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (i_req.u1[i]) begin
                n_exp = 5'(i);
            end
        end
        n_p   = i_req.u2 + 24'h400000;
        n_neg = n_p[23];
    end

    assign n_sq    = 64'(r_m) * 64'(r_m);
    assign n_d     = (29'(5'd24 - r_exp) << 24) - 29'(r_f);
    assign n_lprod = 60'(n_d) * 60'(TWO_LN2_Q30);
    assign n_bit   = 64'd1 << (6'd62 - {r_cnt, 1'b0});
    assign n_trial = r_res + n_bit;
    assign n_dx    = r_cy >>> r_cnt[3:0];
    assign n_dy    = r_cx >>> r_cnt[3:0];
    assign n_atan  = $signed(34'(atan_turn(r_cnt[3:0])));
    assign n_cos   = r_neg ? -r_cx : r_cx;
    assign n_rprod = $signed({1'b0, r_res[27:0]}) * n_cos;

    always_ff @(posedge i_clk) begin
        logic [23:0] p_fold;
        if (!i_rst_n) begin
            r_state    <= G_IDLE;
            o_rsp.done <= 1'b0;
        end else begin
            o_rsp.done <= 1'b0;
            case (r_state)
                G_IDLE: begin
                    if (i_req.start) begin
                        p_fold = n_neg ? (i_req.u2 + 24'h800000) : i_req.u2;
                        r_neg  <= n_neg;
                        r_zero <= (i_req.u1 == 24'd0);
                        r_exp  <= n_exp;
                        r_m    <= 32'(i_req.u1) << (5'd30 - n_exp);
                        r_f    <= 24'd0;
                        r_cx   <= $signed(CORDIC_K0);
                        r_cy   <= '0;
                        r_cz   <= 34'($signed({p_fold, 8'd0}));
                        r_cnt  <= 5'd0;
                        r_state <= G_LOG;
                    end
                end
                G_LOG: begin
                    // The squared mantissa is below 2^62; a carry into bit 61 is a one.
                    if (n_sq[61]) begin
                        r_m <= n_sq[62:31];
                        r_f <= {r_f[22:0], 1'b1};
                    end else begin
                        r_m <= n_sq[61:30];
                        r_f <= {r_f[22:0], 1'b0};
                    end
                    if (!r_cnt[4]) begin
                        if (r_cz >= 0) begin
                            r_cx <= r_cx - n_dx;
                            r_cy <= r_cy + n_dy;
                            r_cz <= r_cz - n_atan;
                        end else begin
                            r_cx <= r_cx + n_dx;
                            r_cy <= r_cy - n_dy;
                            r_cz <= r_cz + n_atan;
                        end
                    end
                    if (r_cnt == 5'd23) begin
                        r_state <= G_LN;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                G_LN: begin
                    r_v     <= {10'd0, (r_zero ? CLAMP_L_Q24 : n_lprod[59:30]), 24'd0};
                    r_res   <= '0;
                    r_cnt   <= 5'd0;
                    r_state <= G_SQRT;
                end
                G_SQRT: begin
                    if (r_v >= n_trial) begin
                        r_v   <= r_v - n_trial;
                        r_res <= (r_res >> 1) + n_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_cnt == 5'd31) begin
                        r_state <= G_MUL;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                G_MUL: begin
                    o_rsp.n    <= n_rprod[59:30];
                    o_rsp.done <= 1'b1;
                    r_state    <= G_IDLE;
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/noisy_target_measurement_gen.sv
// ----------------------------------------------------------------------------
// noisy_target_measurement_gen
// Contact table with noisy position measurements generated on each tick.
// ----------------------------------------------------------------------------
//  Channel    Ports                               Handshake
//  command    i_start, i_cmd, o_busy              beat when i_start && !o_busy
//  result     o_valid, o_meas                     one-cycle strobe, no stall
//  config     i_cfg_we, i_cfg_idx, i_cfg_wdata    write when i_cfg_we
//
// A load beat leaves the block idle. A tick walks the slots, one empty
// slot per cycle; a valid contact is read, moved axis by axis (a multiply
// and an add per axis), written back and given its drop draw, and a kept
// one then, per axis, draws two uniforms, waits on the shared noise unit
// and adds the scaled noise before it is emitted. A result is held until
// the next one is known so that last can be set; the final one leaves
// from the flush state after the walk ends. Reset is synchronous and
// clears control state and valid bits; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module noisy_target_measurement_gen
    import ntm_pkg::*;
#(
    parameter int MAX_CONTACTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_cmd        i_cmd,
    output logic             o_busy,
    output logic             o_valid,
    output t_meas            o_meas,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W = $clog2(MAX_CONTACTS + 1);

    typedef enum logic [3:0] {
        T_IDLE,
        T_SCAN,
        T_RD,
        T_MUL,
        T_ADD,
        T_WB,
        T_DROP,
        T_U1,
        T_U2,
        T_GWAIT,
        T_NMUL,
        T_NADD,
        T_EMIT,
        T_FLUSH
    } t_state;

    t_state                  r_state;
    logic [24:0]             r_thresh;
    logic [15:0]             r_sigma;
    logic [31:0]             r_lcg;
    logic [47:0]             r_time;
    logic [19:0]             r_dt;
    logic [MAX_CONTACTS-1:0] r_valid;
    logic [CNT_W-1:0]        r_idx;
    logic [1:0]              r_axis;
    t_contact                r_ent;
    logic [2:0][31:0]        r_mval;
    logic signed [52:0]      r_prod;
    logic signed [29:0]      r_n;
    logic signed [48:0]      r_nprod;
    logic [23:0]             r_u1;
    logic                    r_pend;
    t_meas                   r_pmeas;

    t_contact                r_mem [MAX_CONTACTS];
    t_contact                r_q;
    logic                    n_we;
    logic [IDX_W-1:0]        n_waddr;
    t_contact                n_wdata;

    logic [31:0]             n_lcg;
    logic [31:0]             n_noise;
    t_gauss_req              r_greq;
    t_gauss_rsp              n_grsp;

    assign n_lcg   = r_lcg * LCG_MUL + LCG_INC;
    assign n_noise = (r_axis == 2'd2) ? r_nprod[48:17] : r_nprod[47:16];
    assign o_busy  = (r_state != T_IDLE);

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_idx[IDX_W-1:0];
        n_wdata = r_ent;
        if (r_state == T_IDLE && i_start && i_cmd.mode == MODE_LOAD
                && 32'(i_cmd.slot) < MAX_CONTACTS) begin
            n_we            = 1'b1;
            n_waddr         = IDX_W'(i_cmd.slot);
            n_wdata.ident   = i_cmd.contact_id;
            n_wdata.pos     = {i_cmd.pos_z, i_cmd.pos_y, i_cmd.pos_x};
            n_wdata.vel     = {i_cmd.vel_z, i_cmd.vel_y, i_cmd.vel_x};
        end else if (r_state == T_WB) begin
            n_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_q <= r_mem[r_idx[IDX_W-1:0]];
    end

    ntm_gauss u_gauss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_greq),
        .o_rsp   (n_grsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_thresh     <= 25'd0;
            r_sigma      <= 16'd256;
            r_lcg        <= 32'd1;
            r_time       <= 48'd0;
            r_valid      <= '0;
            r_pend       <= 1'b0;
            r_greq.start <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            o_valid      <= 1'b0;
            r_greq.start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RNG_SEED:  r_lcg    <= i_cfg_wdata;
                    CFG_DROP_THR:  r_thresh <= i_cfg_wdata[24:0];
                    CFG_NOISE_SIG: r_sigma  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        if (i_cmd.mode == MODE_LOAD) begin
                            if (32'(i_cmd.slot) < MAX_CONTACTS) begin
                                r_valid[IDX_W'(i_cmd.slot)] <= 1'b1;
                            end
                        end else begin
                            r_time  <= r_time + 48'(i_cmd.dt);
                            r_dt    <= i_cmd.dt;
                            r_idx   <= '0;
                            r_state <= T_SCAN;
                        end
                    end
                end
                T_SCAN: begin
                    if (32'(r_idx) >= MAX_CONTACTS) begin
                        r_state <= T_FLUSH;
                    end else if (r_valid[r_idx[IDX_W-1:0]]) begin
                        r_state <= T_RD;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                T_RD: begin
                    r_ent   <= r_q;
                    r_axis  <= 2'd0;
                    r_state <= T_MUL;
                end
                T_MUL: begin
                    r_prod  <= $signed(r_ent.vel[r_axis]) * $signed({1'b0, r_dt});
                    r_state <= T_ADD;
                end
                T_ADD: begin
                    r_ent.pos[r_axis] <= r_ent.pos[r_axis] + r_prod[47:16];
                    if (r_axis == 2'd2) begin
                        r_state <= T_WB;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= T_MUL;
                    end
                end
                T_WB: begin
                    r_state <= T_DROP;
                end
                T_DROP: begin
                    r_lcg <= n_lcg;
                    r_axis <= 2'd0;
                    if (25'(n_lcg[23:0]) < r_thresh) begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= T_SCAN;
                    end else begin
                        r_state <= T_U1;
                    end
                end
                T_U1: begin
                    r_lcg   <= n_lcg;
                    r_u1    <= n_lcg[23:0];
                    r_state <= T_U2;
                end
                T_U2: begin
                    r_lcg        <= n_lcg;
                    r_greq.start <= 1'b1;
                    r_greq.u1    <= r_u1;
                    r_greq.u2    <= n_lcg[23:0];
                    r_state      <= T_GWAIT;
                end
                T_GWAIT: begin
                    if (n_grsp.done) begin
                        r_n     <= n_grsp.n;
                        r_state <= T_NMUL;
                    end
                end
                T_NMUL: begin
                    r_nprod <= r_n * $signed({1'b0, r_sigma});
                    r_state <= T_NADD;
                end
                T_NADD: begin
                    r_mval[r_axis] <= r_ent.pos[r_axis] + n_noise;
                    if (r_axis == 2'd2) begin
                        r_state <= T_EMIT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= T_U1;
                    end
                end
                T_EMIT: begin
                    // The held result is known not to be last once another exists.
                    if (r_pend) begin
                        o_valid <= 1'b1;
                        o_meas  <= {r_pmeas.meas_id, r_pmeas.time_stamp, r_pmeas.meas_x,
                                    r_pmeas.meas_y, r_pmeas.meas_z, 1'b0};
                    end
                    r_pend             <= 1'b1;
                    r_pmeas.meas_id    <= r_ent.ident;
                    r_pmeas.time_stamp <= r_time;
                    r_pmeas.meas_x     <= r_mval[0];
                    r_pmeas.meas_y     <= r_mval[1];
                    r_pmeas.meas_z     <= r_mval[2];
                    r_pmeas.last       <= 1'b0;
                    r_idx              <= r_idx + CNT_W'(1);
                    r_state            <= T_SCAN;
                end
                T_FLUSH: begin
                    if (r_pend) begin
                        o_valid <= 1'b1;
                        o_meas  <= {r_pmeas.meas_id, r_pmeas.time_stamp, r_pmeas.meas_x,
                                    r_pmeas.meas_y, r_pmeas.meas_z, 1'b1};
                    end
                    r_pend  <= 1'b0;
                    r_state <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
